FILE: src/ots_pkg.sv
package ots_pkg;

  localparam int LEN_W  = 16;
  localparam int TRIM_W = 8;
  localparam int STEP_W = 7;
  localparam int IDX_W  = 8;

  typedef logic [IDX_W-1:0] reg_idx_t;

  localparam reg_idx_t REG_TARGET_LENGTH = 8'd0;
  localparam reg_idx_t REG_START_TRIM    = 8'd1;

  localparam logic [LEN_W-1:0]  TARGET_LENGTH_RESET = 16'd2356;
  localparam logic [TRIM_W-1:0] START_TRIM_RESET    = 8'd101;
  localparam logic [LEN_W-1:0]  DEVIATION_MAX       = 16'hFFFF;

  typedef struct packed {
    logic [LEN_W-1:0] frame_length;
    logic             restart;
  } item_t;

  typedef struct packed {
    logic [TRIM_W-1:0] trim;
    logic              done_res;
  } result_t;

endpackage

FILE: src/oscillator_trim_search.sv
// Oscillator trim search.
// Feed one measured frame length per word on the s_axis channel; tuser[0]
// marks a measurement taken at start_trim and begins a new search. Every
// accepted word yields exactly one m_axis word: the trim to apply next, or,
// with done set in tuser[0], the best trim found. After a restart the trim
// moves by INITIAL_STEP, then by half the step on each later measurement
// until the step reaches zero.
// An accepted word goes through the input register, then the state
// update, which loads the result register in the same cycle, so a
// word is taken every cycle while the receiver takes results.
// When the receiver stalls the result register holds, the input register
// fills, and s_axis_tready drops once both are occupied.
// Reset clears both stages and loads target_length 2356, start_trim 101
// and the idle state, whose result is trim 101 with done set.
// Write the cfg channel (index 0 target_length, 1 start_trim, others
// ignored) only while no word is in flight; cfg_ready is always high.
module oscillator_trim_search #(
  parameter int INITIAL_STEP = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] frame_length
  input  logic [0:0]  s_axis_tuser,   // [0] restart
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] trim
  output logic [0:0]  m_axis_tuser,   // [0] done_res
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [ots_pkg::IDX_W-1:0] cfg_index,
  input  logic [15:0] cfg_data
);
  import ots_pkg::*;

  logic [LEN_W-1:0]  target_length;
  logic [TRIM_W-1:0] start_trim;

  item_t   in_item, held_item;
  result_t core_result;
  logic    held_valid, held_take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_length <= TARGET_LENGTH_RESET;
      start_trim    <= START_TRIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TARGET_LENGTH: target_length <= cfg_data;
        REG_START_TRIM:    start_trim    <= cfg_data[TRIM_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_item.frame_length = s_axis_tdata;
  assign in_item.restart      = s_axis_tuser[0];

  // advance the held word when the result register is free or drains
  assign held_take = held_valid && (!m_axis_tvalid || m_axis_tready);

  ots_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_item    (in_item),
    .held_valid (held_valid),
    .held_take  (held_take),
    .held_item  (held_item)
  );

  ots_core #(
    .INITIAL_STEP (INITIAL_STEP)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .en            (held_take),
    .item          (held_item),
    .target_length (target_length),
    .start_trim    (start_trim),
    .result        (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (!m_axis_tvalid || m_axis_tready) begin
      m_axis_tvalid <= held_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (held_take) begin
      m_axis_tdata    <= core_result.trim;
      m_axis_tuser[0] <= core_result.done_res;
    end
  end

endmodule

FILE: src/ots_in_stage.sv
module ots_in_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  ots_pkg::item_t in_item,
  output logic          held_valid,
  input  logic          held_take,
  output ots_pkg::item_t held_item
);
  import ots_pkg::*;

  assign in_ready = !held_valid || held_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  // load a new word whenever the slot is free or drains this cycle
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_item <= in_item;
    end
  end

endmodule

FILE: src/ots_core.sv
module ots_core #(
  parameter int INITIAL_STEP = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  ots_pkg::item_t            item,
  input  logic [ots_pkg::LEN_W-1:0]  target_length,
  input  logic [ots_pkg::TRIM_W-1:0] start_trim,
  output ots_pkg::result_t          result
);
  import ots_pkg::*;

  localparam logic [STEP_W-1:0] STEP_INIT = STEP_W'(INITIAL_STEP);

  logic [TRIM_W-1:0] test_trim, test_trim_next;
  logic [TRIM_W-1:0] best_trim, best_trim_next;
  logic [LEN_W-1:0]  best_deviation, best_deviation_next;
  logic [STEP_W-1:0] step_size, step_size_next;
  logic              searching, searching_next;

  logic              below;
  logic [LEN_W-1:0]  dev;
  logic [TRIM_W-1:0] base_trim;
  logic [STEP_W-1:0] move_step;
  logic [TRIM_W-1:0] moved_trim;

  assign below = item.frame_length < target_length;
  assign dev   = below ? (target_length - item.frame_length)
                       : (item.frame_length - target_length);

  assign base_trim  = item.restart ? start_trim : test_trim;
  assign move_step  = item.restart ? STEP_INIT : (step_size >> 1);
  assign moved_trim = below ? (base_trim + {1'b0, move_step})
                            : (base_trim - {1'b0, move_step});

  always_comb begin
    test_trim_next      = test_trim;
    best_trim_next      = best_trim;
    best_deviation_next = best_deviation;
    step_size_next      = step_size;
    searching_next      = searching;
    result.trim         = best_trim;
    result.done_res     = 1'b1;
    if (item.restart) begin
      best_trim_next      = start_trim;
      best_deviation_next = DEVIATION_MAX;
      step_size_next      = move_step;
      searching_next      = move_step != '0;
      if (move_step != '0) begin
        test_trim_next  = moved_trim;
        result.trim     = moved_trim;
        result.done_res = 1'b0;
      end else begin
        test_trim_next = start_trim;
        result.trim    = start_trim;
      end
    end else if (searching) begin
      if (dev < best_deviation) begin
        best_deviation_next = dev;
        best_trim_next      = test_trim;
        result.trim         = test_trim;
      end
      step_size_next = move_step;
      if (move_step == '0) begin
        searching_next = 1'b0;
      end else begin
        test_trim_next  = moved_trim;
        result.trim     = moved_trim;
        result.done_res = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      test_trim      <= START_TRIM_RESET;
      best_trim      <= START_TRIM_RESET;
      best_deviation <= DEVIATION_MAX;
      step_size      <= '0;
      searching      <= 1'b0;
    end else if (en) begin
      test_trim      <= test_trim_next;
      best_trim      <= best_trim_next;
      best_deviation <= best_deviation_next;
      step_size      <= step_size_next;
      searching      <= searching_next;
    end
  end

endmodule

FILE: src/ots_checker.sv
module ots_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic [0:0] m_axis_tuser
);

  // a cleared pipeline shows no result word
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !m_axis_tvalid)
    else $error("result valid right after reset");

  // an empty result register always leaves room on the input side
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while result register is empty");

  // a stalled result word holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result word changed");

endmodule

bind oscillator_trim_search ots_checker u_ots_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

FILE: verif/oscillator_trim_search_tb.sv
module oscillator_trim_search_tb;
  import ots_pkg::*;

  localparam int INIT_STEP = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD_AT = 700;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int PHASE_WORDS = 250;
  localparam reg_idx_t REG_UNUSED_FIRST = 8'd2;
  localparam reg_idx_t REG_UNUSED_LAST = '1;

  // directed probe: frame length, restart, and a hand-typed result where one is given
  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic              restart;
    logic              typed;
    logic [TRIM_W-1:0] trim;
    logic              done_res;
  } probe_t;

  // reset registers: target 2356, start trim 101
  localparam probe_t PROBES [0:17] = '{
    '{16'd0,     1'b0, 1'b1, 8'd101, 1'b1},  // idle right after reset
    '{16'hFFFF,  1'b0, 1'b1, 8'd101, 1'b1},
    '{16'd0,     1'b1, 1'b1, 8'd109, 1'b0},  // restart below target: step up
    '{16'd2356,  1'b0, 1'b0, 8'd0,   1'b0},  // exact hit
    '{16'd2356,  1'b0, 1'b0, 8'd0,   1'b0},  // tie on zero deviation
    '{16'hFFFF,  1'b0, 1'b0, 8'd0,   1'b0},
    '{16'd0,     1'b0, 1'b0, 8'd0,   1'b0},  // step runs out
    '{16'd12345, 1'b0, 1'b0, 8'd0,   1'b0},  // idle after done
    '{16'hFFFF,  1'b1, 1'b1, 8'd93,  1'b0},  // restart above target: step down
    '{16'd2355,  1'b0, 1'b0, 8'd0,   1'b0},
    '{16'd2356,  1'b1, 1'b1, 8'd93,  1'b0},  // restart in mid-search, equal goes down
    '{16'd1000,  1'b0, 1'b0, 8'd0,   1'b0},
    '{16'd3000,  1'b0, 1'b0, 8'd0,   1'b0},
    '{16'd2357,  1'b0, 1'b0, 8'd0,   1'b0},
    '{16'd2355,  1'b0, 1'b0, 8'd0,   1'b0},  // tie on deviation of one
    '{16'd0,     1'b0, 1'b0, 8'd0,   1'b0},
    '{16'hAAAA,  1'b1, 1'b0, 8'd0,   1'b0},
    '{16'h5555,  1'b0, 1'b0, 8'd0,   1'b0}
  };

  logic              clk;
  logic              rst;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [15:0]       s_axis_tdata;
  logic [0:0]        s_axis_tuser;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [7:0]        m_axis_tdata;
  logic [0:0]        m_axis_tuser;
  logic              cfg_valid;
  logic              cfg_ready;
  reg_idx_t          cfg_index;
  logic [15:0]       cfg_data;

  // search state mirrored from the words accepted so far
  logic [LEN_W-1:0]  target_len;
  logic [TRIM_W-1:0] start_trim_r;
  logic [TRIM_W-1:0] trial_trim;
  logic [TRIM_W-1:0] best_trim;
  logic [LEN_W-1:0]  best_dev;
  logic [STEP_W-1:0] trim_step;
  logic              search_on;

  result_t           pending_trims[$];
  result_t           want;
  logic [LEN_W-1:0]  last_len;
  int unsigned       feed_gap_max;
  int unsigned       drain_stall_max;
  int unsigned       idle_cycles;
  int                errors;

  oscillator_trim_search #(
    .INITIAL_STEP(INIT_STEP)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function void nudge_trim(input logic [LEN_W-1:0] len);
    if (len < target_len) begin
      trial_trim = trial_trim + {1'b0, trim_step};
    end else begin
      trial_trim = trial_trim - {1'b0, trim_step};
    end
  endfunction

  function result_t advance_search(input logic [LEN_W-1:0] len, input logic restart);
    logic [LEN_W-1:0] dev;
    result_t res;
    res.trim = best_trim;
    res.done_res = 1'b1;
    if (restart) begin
      trial_trim = start_trim_r;
      best_trim = start_trim_r;
      best_dev = DEVIATION_MAX;
      trim_step = STEP_W'(INIT_STEP);
      search_on = trim_step != '0;
      if (search_on) begin
        nudge_trim(len);
        res.trim = trial_trim;
        res.done_res = 1'b0;
      end else begin
        res.trim = best_trim;
      end
      return res;
    end
    if (search_on) begin
      dev = (len >= target_len) ? len - target_len : target_len - len;
      // strictly smaller only: ties keep the earlier trim
      if (dev < best_dev) begin
        best_dev = dev;
        best_trim = trial_trim;
      end
      trim_step = trim_step >> 1;
      if (trim_step == '0) begin
        search_on = 1'b0;
      end else begin
        nudge_trim(len);
        res.trim = trial_trim;
        res.done_res = 1'b0;
        return res;
      end
    end
    res.trim = best_trim;
    return res;
  endfunction

  function automatic logic [LEN_W-1:0] pick_length();
    int unsigned sel;
    sel = $urandom_range(0, 7);
    case (sel)
      0: return LEN_W'($urandom);
      1: return last_len;
      2: return ($urandom_range(0, 1) != 0) ? DEVIATION_MAX : '0;
      default: return target_len + LEN_W'($urandom_range(0, 96)) - LEN_W'(48);
    endcase
  endfunction

  task automatic send_measurement(input logic [LEN_W-1:0] len, input logic restart,
                                  input logic typed, input result_t typed_res);
    int unsigned gap;
    result_t got;
    gap = $urandom_range(0, feed_gap_max);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= len;
    s_axis_tuser <= restart;
    do @(posedge clk); while (!s_axis_tready);
    last_len = len;
    got = advance_search(len, restart);
    pending_trims.push_back(typed ? typed_res : got);
  endtask

  // drain the pipe, then program both registers and optionally an unused index
  task automatic reprogram(input logic [LEN_W-1:0] target, input logic [TRIM_W-1:0] start,
                           input logic junk);
    s_axis_tvalid <= 1'b0;
    while (pending_trims.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= REG_TARGET_LENGTH;
    cfg_data <= target;
    do @(posedge clk); while (!cfg_ready);
    target_len = target;
    cfg_index <= REG_START_TRIM;
    cfg_data <= {8'd0, start};
    do @(posedge clk); while (!cfg_ready);
    start_trim_r = start;
    if (junk) begin
      cfg_index <= reg_idx_t'($urandom_range(REG_UNUSED_FIRST, REG_UNUSED_LAST));
      cfg_data <= 16'($urandom);
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input int unsigned count);
    int unsigned sent;
    int unsigned kind;
    int unsigned n;
    sent = 0;
    while (sent < count) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        // full search is a restart and four measurements; sometimes cut short or overrun
        n = 4;
        if ($urandom_range(0, 4) == 0) n = $urandom_range(0, 6);
        send_measurement(pick_length(), 1'b1, 1'b0, '0);
        sent++;
        repeat (n) begin
          send_measurement(pick_length(), 1'b0, 1'b0, '0);
          sent++;
        end
      end else begin
        send_measurement(LEN_W'($urandom), $urandom_range(0, 3) == 0, 1'b0, '0);
        sent++;
      end
    end
  endtask

  initial begin
    int unsigned ph;
    result_t typed_res;
    rst <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_TARGET_LENGTH;
    cfg_data <= '0;
    errors = 0;
    last_len = '0;
    feed_gap_max = 19;
    drain_stall_max = 19;
    target_len = TARGET_LENGTH_RESET;
    start_trim_r = START_TRIM_RESET;
    trial_trim = START_TRIM_RESET;
    best_trim = START_TRIM_RESET;
    best_dev = DEVIATION_MAX;
    trim_step = '0;
    search_on = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < $size(PROBES); i++) begin
      typed_res.trim = PROBES[i].trim;
      typed_res.done_res = PROBES[i].done_res;
      send_measurement(PROBES[i].len, PROBES[i].restart, PROBES[i].typed, typed_res);
    end

    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: reprogram('0, '1, 1'b0);
        1: reprogram('1, '0, 1'b0);
        2: reprogram('1, '1, 1'b1);
        3: reprogram('0, '0, 1'b0);
        default: reprogram(LEN_W'($urandom), TRIM_W'($urandom), 1'b1);
      endcase
      feed_gap_max = (ph == 1 || ph == 2) ? 0 : 19;
      drain_stall_max = (ph == 1 || ph == 4) ? 0 : 19;
      run_phase(PHASE_WORDS);
    end
    feed_gap_max = 19;
    drain_stall_max = 19;
    reprogram(TARGET_LENGTH_RESET, START_TRIM_RESET, 1'b0);
    run_phase(40);

    s_axis_tvalid <= 1'b0;
    while (pending_trims.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0 && pending_trims.size() == 0) begin
      $display("oscillator_trim_search regression: pass");
    end else begin
      $display("oscillator_trim_search regression: fail");
    end
    $finish;
  end

  // result side: random stalls, plus one long hold to back the input up
  initial begin
    int unsigned stall;
    int unsigned drained;
    drained = 0;
    m_axis_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (drained == LONG_HOLD_AT) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end
      stall = $urandom_range(0, drain_stall_max);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      drained++;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_trims.size() == 0) begin
        $error("unexpected word: trim %0d done_res %0d", m_axis_tdata, m_axis_tuser[0]);
        errors++;
      end else begin
        want = pending_trims.pop_front();
        if (m_axis_tdata !== want.trim) begin
          $error("trim: expected %0d, got %0d", want.trim, m_axis_tdata);
          errors++;
        end
        if (m_axis_tuser[0] !== want.done_res) begin
          $error("done_res: expected %0d, got %0d", want.done_res, m_axis_tuser[0]);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("oscillator_trim_search regression: fail");
      $finish;
    end
  end

endmodule
